/* rtl/core/ryp_pkg.sv */
// ----------------------------------------------------------------------------
// ryp_pkg
// Shared constants, types and helpers for the RGB to YUV 4:2:2 packer.
// ----------------------------------------------------------------------------
package ryp_pkg;

	localparam int unsigned COEF_FRAC_BITS = 20;

	// widened channel: (c << 5) - 0x18 + offset, always within 15-bit signed
	localparam int unsigned CH_W   = 15;
	// every coefficient magnitude is below 2^(COEF_FRAC_BITS-5)
	localparam int unsigned COEF_W = COEF_FRAC_BITS - 4;
	localparam int unsigned SUM_W  = COEF_FRAC_BITS + 14;
	localparam int unsigned YUV_W  = 10;

	localparam logic signed [CH_W-1:0] RED_OFS = CH_W'(32'sh166F - 32'sh18);
	localparam logic signed [CH_W-1:0] GRN_OFS = CH_W'(-32'sh10EE - 32'sh18);
	localparam logic signed [CH_W-1:0] BLU_OFS = CH_W'(32'sh1C5B - 32'sh18);

	// round(n * 2^F / 1e8), ties up
	localparam longint unsigned RND = 64'd50000000;
	localparam longint unsigned DEN = 64'd100000000;

	localparam longint unsigned M_YR = ((64'd933073  << COEF_FRAC_BITS) + RND) / DEN;
	localparam longint unsigned M_YG = ((64'd1835380 << COEF_FRAC_BITS) + RND) / DEN;
	localparam longint unsigned M_YB = ((64'd356543  << COEF_FRAC_BITS) + RND) / DEN;
	localparam longint unsigned M_UR = ((64'd527299  << COEF_FRAC_BITS) + RND) / DEN;
	localparam longint unsigned M_UG = ((64'd1037220 << COEF_FRAC_BITS) + RND) / DEN;
	localparam longint unsigned M_UB = ((64'd1564510 << COEF_FRAC_BITS) + RND) / DEN;
	localparam longint unsigned M_VR = ((64'd1567410 << COEF_FRAC_BITS) + RND) / DEN;
	localparam longint unsigned M_VG = ((64'd1312450 << COEF_FRAC_BITS) + RND) / DEN;
	localparam longint unsigned M_VB = ((64'd254958  << COEF_FRAC_BITS) + RND) / DEN;

	localparam logic signed [COEF_W-1:0] K_YR =  COEF_W'(M_YR);
	localparam logic signed [COEF_W-1:0] K_YG =  COEF_W'(M_YG);
	localparam logic signed [COEF_W-1:0] K_YB =  COEF_W'(M_YB);
	localparam logic signed [COEF_W-1:0] K_UR = -COEF_W'(M_UR);
	localparam logic signed [COEF_W-1:0] K_UG = -COEF_W'(M_UG);
	localparam logic signed [COEF_W-1:0] K_UB =  COEF_W'(M_UB);
	localparam logic signed [COEF_W-1:0] K_VR =  COEF_W'(M_VR);
	localparam logic signed [COEF_W-1:0] K_VG = -COEF_W'(M_VG);
	localparam logic signed [COEF_W-1:0] K_VB = -COEF_W'(M_VB);

	typedef struct packed {
		logic valid;
		logic frame_start;
	} ctl_t;

	typedef struct packed {
		logic signed [YUV_W-1:0] y;
		logic signed [YUV_W-1:0] u;
		logic signed [YUV_W-1:0] v;
	} yuv_t;

	// saturate to 0..255
	function automatic logic [7:0] clamp8(input logic signed [YUV_W-1:0] x);
		logic [7:0] r;
		if (x[YUV_W-1]) begin
			r = 8'd0;
		end else if (|x[YUV_W-2:8]) begin
			r = 8'hFF;
		end else begin
			r = x[7:0];
		end
		return r;
	endfunction

endpackage

/* rtl/core/rgb_to_yuv422_packer.sv */
// ----------------------------------------------------------------------------
// rgb_to_yuv422_packer
// RGB888 pixel stream to packed YUV 4:2:2 (BT.601 weights, fixed point).
// ----------------------------------------------------------------------------
// Usage:
//   Pixel channel: pix_valid/pix_ready carry red, green, blue and
//   frame_start. One pixel may be taken every cycle.
//   Word channel: word_valid/word_ready carry word_first (U:Y0) and
//   word_second (V:Y1), one word per completed pixel pair.
//   Pixels pair up in arrival order; frame_start drops any half pair and
//   starts a new one with the current pixel.
//   Pipeline: three register stages (input, weighted sums, output); the word
//   for a pair is formed from the sums and loaded into the output register.
//   Throughput: one pixel per cycle while the pipe is not stalled, so one
//   word for every two pixels, as the pixels are taken in pairs.
//   Stall: while a word waits with word_ready low the whole pipe freezes and
//   pix_ready drops; nothing is lost. A waiting word never blocks input when
//   word_ready is high, as the output register is reloaded on that edge.
//   Reset: arst_n clears all valid flags and the pairing state; the first
//   pixel after reset opens a new pair.
// ----------------------------------------------------------------------------
module rgb_to_yuv422_packer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pix_valid,
	output logic        pix_ready,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic        frame_start,
	output logic        word_valid,
	input  logic        word_ready,
	output logic [15:0] word_first,
	output logic [15:0] word_second
);

	logic          adv;
	ryp_pkg::ctl_t ctl_s1, ctl_s2;
	logic [7:0]    red_s1, green_s1, blue_s1;
	ryp_pkg::yuv_t yuv;
	logic          held;

	assign adv       = !word_valid || word_ready;
	assign pix_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.valid       <= pix_valid;
			ctl_s1.frame_start <= frame_start;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && pix_valid) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
		end
	end

	ryp_csc u_csc (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.ctl_s1   (ctl_s1),
		.red_s1   (red_s1),
		.green_s1 (green_s1),
		.blue_s1  (blue_s1),
		.ctl_s2   (ctl_s2),
		.yuv      (yuv)
	);

	ryp_pair u_pair (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.ctl_s2      (ctl_s2),
		.yuv         (yuv),
		.held        (held),
		.word_valid  (word_valid),
		.word_first  (word_first),
		.word_second (word_second)
	);

	// only a waiting word may hold off the pixel side
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready |-> (word_valid && !word_ready))
		else $error("pixel side stalled without a waiting word");

	// a frame start always leaves exactly the current pixel held
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && ctl_s2.valid && ctl_s2.frame_start) |=> (held && !word_valid))
		else $error("frame start did not restart pairing");

	// the second pixel of a pair releases the hold and yields a word
	a_pair_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && ctl_s2.valid && !ctl_s2.frame_start && held) |=> (!held && word_valid))
		else $error("completed pair did not produce a word");

endmodule

/* rtl/core/ryp_csc.sv */
// ----------------------------------------------------------------------------
// ryp_csc
// Colour conversion stage: widens the channels, forms the three weighted
// sums into a register, then truncates them toward zero.
// ----------------------------------------------------------------------------
module ryp_csc (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  ryp_pkg::ctl_t     ctl_s1,
	input  logic [7:0]        red_s1,
	input  logic [7:0]        green_s1,
	input  logic [7:0]        blue_s1,
	output ryp_pkg::ctl_t     ctl_s2,
	output ryp_pkg::yuv_t     yuv
);

	logic signed [ryp_pkg::CH_W-1:0]  r_w, g_w, b_w;
	logic signed [ryp_pkg::SUM_W-1:0] sy, su, sv;
	logic signed [ryp_pkg::SUM_W-1:0] sy_s2, su_s2, sv_s2;
	logic signed [ryp_pkg::SUM_W-1:0] ty, tu, tv;
	ryp_pkg::ctl_t                    ctl_q;

	assign r_w = $signed(ryp_pkg::CH_W'({red_s1, 5'b0}))   + ryp_pkg::RED_OFS;
	assign g_w = $signed(ryp_pkg::CH_W'({green_s1, 5'b0})) + ryp_pkg::GRN_OFS;
	assign b_w = $signed(ryp_pkg::CH_W'({blue_s1, 5'b0}))  + ryp_pkg::BLU_OFS;

	assign sy = ryp_pkg::SUM_W'(ryp_pkg::K_YR) * ryp_pkg::SUM_W'(r_w)
		+ ryp_pkg::SUM_W'(ryp_pkg::K_YG) * ryp_pkg::SUM_W'(g_w)
		+ ryp_pkg::SUM_W'(ryp_pkg::K_YB) * ryp_pkg::SUM_W'(b_w);
	assign su = ryp_pkg::SUM_W'(ryp_pkg::K_UR) * ryp_pkg::SUM_W'(r_w)
		+ ryp_pkg::SUM_W'(ryp_pkg::K_UG) * ryp_pkg::SUM_W'(g_w)
		+ ryp_pkg::SUM_W'(ryp_pkg::K_UB) * ryp_pkg::SUM_W'(b_w);
	assign sv = ryp_pkg::SUM_W'(ryp_pkg::K_VR) * ryp_pkg::SUM_W'(r_w)
		+ ryp_pkg::SUM_W'(ryp_pkg::K_VG) * ryp_pkg::SUM_W'(g_w)
		+ ryp_pkg::SUM_W'(ryp_pkg::K_VB) * ryp_pkg::SUM_W'(b_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (adv) begin
			ctl_q <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sy_s2 <= sy;
			su_s2 <= su;
			sv_s2 <= sv;
		end
	end

	// bias negatives by 2^F-1 so the shift truncates toward zero
	localparam logic signed [ryp_pkg::SUM_W-1:0] BIAS =
		ryp_pkg::SUM_W'((64'd1 << ryp_pkg::COEF_FRAC_BITS) - 64'd1);

	assign ty = sy_s2 + (sy_s2[ryp_pkg::SUM_W-1] ? BIAS : '0);
	assign tu = su_s2 + (su_s2[ryp_pkg::SUM_W-1] ? BIAS : '0);
	assign tv = sv_s2 + (sv_s2[ryp_pkg::SUM_W-1] ? BIAS : '0);

	assign yuv.y  = ty[ryp_pkg::COEF_FRAC_BITS +: ryp_pkg::YUV_W];
	assign yuv.u  = tu[ryp_pkg::COEF_FRAC_BITS +: ryp_pkg::YUV_W];
	assign yuv.v  = tv[ryp_pkg::COEF_FRAC_BITS +: ryp_pkg::YUV_W];
	assign ctl_s2 = ctl_q;

endmodule

/* rtl/core/ryp_pair.sv */
// ----------------------------------------------------------------------------
// ryp_pair
// Pairing stage: holds the first pixel of a pair, averages chroma over the
// pair and loads the packed 4:2:2 word into the output register.
// ----------------------------------------------------------------------------
module ryp_pair (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  ryp_pkg::ctl_t ctl_s2,
	input  ryp_pkg::yuv_t yuv,
	output logic          held,
	output logic          word_valid,
	output logic [15:0]   word_first,
	output logic [15:0]   word_second
);

	logic                             held_q;
	logic                             valid_q;
	ryp_pkg::yuv_t                    hold_q;
	logic [15:0]                      first_q, second_q;
	logic                             pending;
	logic                             emit;
	logic signed [ryp_pkg::YUV_W:0]   usum, vsum, ut, vt;
	logic signed [ryp_pkg::YUV_W-1:0] au, av;

	// frame start drops a held pixel
	assign pending = held_q && !ctl_s2.frame_start;
	assign emit    = ctl_s2.valid && pending;

	assign usum = (ryp_pkg::YUV_W+1)'(hold_q.u) + (ryp_pkg::YUV_W+1)'(yuv.u);
	assign vsum = (ryp_pkg::YUV_W+1)'(hold_q.v) + (ryp_pkg::YUV_W+1)'(yuv.v);
	assign ut   = usum + (ryp_pkg::YUV_W+1)'(usum[ryp_pkg::YUV_W]);
	assign vt   = vsum + (ryp_pkg::YUV_W+1)'(vsum[ryp_pkg::YUV_W]);
	assign au   = ut[ryp_pkg::YUV_W:1];
	assign av   = vt[ryp_pkg::YUV_W:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= 1'b0;
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= emit;
			if (ctl_s2.valid) begin
				held_q <= !pending;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctl_s2.valid) begin
			if (!pending) begin
				hold_q <= yuv;
			end else begin
				first_q  <= {ryp_pkg::clamp8(au), ryp_pkg::clamp8(hold_q.y)};
				second_q <= {ryp_pkg::clamp8(av), ryp_pkg::clamp8(yuv.y)};
			end
		end
	end

	assign held        = held_q;
	assign word_valid  = valid_q;
	assign word_first  = first_q;
	assign word_second = second_q;

endmodule

/* test/rgb_to_yuv422_packer_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_yuv422_packer_tb
// Drives RGB pixels, with and without frame starts, through the packer.
// Each packed word is checked against a fixed-point BT.601 conversion and
// pairing model in the bench, or a pinned word for pinned rows. Both sides
// idle in random bursts; one long receiver hold-off stalls the pixel input.
// ----------------------------------------------------------------------------
module rgb_to_yuv422_packer_tb;

	localparam int FRAC         = 20;
	localparam int RANDOM_PIX   = 800;
	localparam int CALM_PIX     = 150;
	localparam int HOLD_AFTER   = 60;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 8;

	localparam longint FX_ONE = longint'(1) << FRAC;
	localparam longint K_YR = ((longint'(933073)  << FRAC) + 50000000) / 100000000;
	localparam longint K_YG = ((longint'(1835380) << FRAC) + 50000000) / 100000000;
	localparam longint K_YB = ((longint'(356543)  << FRAC) + 50000000) / 100000000;
	localparam longint K_UR = ((longint'(527299)  << FRAC) + 50000000) / 100000000;
	localparam longint K_UG = ((longint'(1037220) << FRAC) + 50000000) / 100000000;
	localparam longint K_UB = ((longint'(1564510) << FRAC) + 50000000) / 100000000;
	localparam longint K_VR = ((longint'(1567410) << FRAC) + 50000000) / 100000000;
	localparam longint K_VG = ((longint'(1312450) << FRAC) + 50000000) / 100000000;
	localparam longint K_VB = ((longint'(254958)  << FRAC) + 50000000) / 100000000;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        frame_start;
		logic        pinned;
		logic [15:0] pin_first;
		logic [15:0] pin_second;
	} pix_item_t;

	typedef struct packed {
		logic [15:0] first;
		logic [15:0] second;
	} yuv_word_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        pix_valid = 1'b0;
	logic        pix_ready;
	logic [7:0]  red = 8'h00;
	logic [7:0]  green = 8'h00;
	logic [7:0]  blue = 8'h00;
	logic        frame_start = 1'b0;
	logic        word_valid;
	logic        word_ready = 1'b0;
	logic [15:0] word_first;
	logic [15:0] word_second;

	// bench-side companions of the pixel payload
	logic        row_pinned = 1'b0;
	logic [15:0] row_first = 16'h0000;
	logic [15:0] row_second = 16'h0000;

	logic        calm = 1'b0;
	int          pix_taken = 0;
	int          quiet = 0;
	int          mismatches = 0;
	int          gap_weight = 0;
	bit          long_hold_done = 1'b0;

	// pairing state of the model
	bit                pair_open = 1'b0;
	logic signed [9:0] held_y = '0;
	logic signed [9:0] held_cb = '0;
	logic signed [9:0] held_cr = '0;

	yuv_word_t pending_words[$];

	// pinned rows: black, white and pure red pairs, then black with white
	pix_item_t directed_rows [22] = '{
		'{8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 16'h0000, 16'h0000},
		'{8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 16'h8000, 16'h8000},
		'{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 16'h0000, 16'h0000},
		'{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 16'h80FE, 16'h80FE},
		'{8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, 16'h0000, 16'h0000},
		'{8'hFF, 8'h00, 8'h00, 1'b0, 1'b1, 16'h554B, 16'hFF4B},
		'{8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 16'h0000, 16'h0000},
		'{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 16'h8000, 16'h80FE},
		'{8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, 16'h0000, 16'h0000},
		'{8'h00, 8'h00, 8'hFF, 1'b1, 1'b0, 16'h0000, 16'h0000},
		'{8'h00, 8'h00, 8'hFF, 1'b0, 1'b0, 16'h0000, 16'h0000},
		'{8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, 16'h0000, 16'h0000},
		'{8'h00, 8'hFF, 8'h00, 1'b1, 1'b0, 16'h0000, 16'h0000},
		'{8'h00, 8'hFF, 8'h00, 1'b1, 1'b0, 16'h0000, 16'h0000},
		'{8'hFF, 8'hFF, 8'h00, 1'b0, 1'b0, 16'h0000, 16'h0000},
		'{8'h00, 8'hFF, 8'hFF, 1'b0, 1'b0, 16'h0000, 16'h0000},
		'{8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0, 16'h0000, 16'h0000},
		'{8'hAA, 8'h55, 8'hAA, 1'b0, 1'b0, 16'h0000, 16'h0000},
		'{8'h55, 8'hAA, 8'h55, 1'b0, 1'b0, 16'h0000, 16'h0000},
		'{8'h80, 8'h80, 8'h80, 1'b1, 1'b0, 16'h0000, 16'h0000},
		'{8'h7F, 8'h7F, 8'h7F, 1'b1, 1'b0, 16'h0000, 16'h0000},
		'{8'h01, 8'h02, 8'h04, 1'b0, 1'b0, 16'h0000, 16'h0000}
	};

	rgb_to_yuv422_packer u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix_valid   (pix_valid),
		.pix_ready   (pix_ready),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.frame_start (frame_start),
		.word_valid  (word_valid),
		.word_ready  (word_ready),
		.word_first  (word_first),
		.word_second (word_second)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// weighted sum, quotient truncated toward zero
	function automatic int weigh_fx(input longint kr, input longint kg, input longint kb,
			input longint r, input longint g, input longint b);
		longint s;
		s = kr * r + kg * g + kb * b;
		return int'(s / FX_ONE);
	endfunction

	function automatic logic [7:0] sat_byte(input int x);
		if (x < 0) begin
			return 8'h00;
		end else if (x > 255) begin
			return 8'hFF;
		end
		return 8'(x);
	endfunction

	// converts one pixel and advances the pairing; word_due when a pair closes
	task automatic pack_pixel(input logic [7:0] r8, input logic [7:0] g8, input logic [7:0] b8,
			input logic fs, output bit word_due, output yuv_word_t w);
		longint wr, wg, wb;
		int y, cb, cr, avg_cb, avg_cr;
		wr = (longint'(r8) << 5) - 64'sd24 + 64'sh166F;
		wg = (longint'(g8) << 5) - 64'sd24 - 64'sh10EE;
		wb = (longint'(b8) << 5) - 64'sd24 + 64'sh1C5B;
		y  = weigh_fx(K_YR, K_YG, K_YB, wr, wg, wb);
		cb = weigh_fx(-K_UR, -K_UG, K_UB, wr, wg, wb);
		cr = weigh_fx(K_VR, -K_VG, -K_VB, wr, wg, wb);
		w = '0;
		word_due = 1'b0;
		if (fs) begin
			pair_open = 1'b0;
		end
		if (!pair_open) begin
			held_y = 10'(y);
			held_cb = 10'(cb);
			held_cr = 10'(cr);
			pair_open = 1'b1;
		end else begin
			avg_cb = (int'(held_cb) + cb) / 2;
			avg_cr = (int'(held_cr) + cr) / 2;
			w.first = {sat_byte(avg_cb), sat_byte(int'(held_y))};
			w.second = {sat_byte(avg_cr), sat_byte(y)};
			pair_open = 1'b0;
			word_due = 1'b1;
		end
	endtask

	function automatic logic [7:0] pick_channel();
		case ($urandom_range(0, 7))
			0: begin
				return 8'h00;
			end
			1: begin
				return 8'hFF;
			end
			default: begin
				return 8'($urandom);
			end
		endcase
	endfunction

	function automatic pix_item_t random_pixel();
		pix_item_t p;
		p = '0;
		p.red = pick_channel();
		p.green = pick_channel();
		p.blue = pick_channel();
		p.frame_start = ($urandom_range(0, 15) == 0);
		return p;
	endfunction

	// offers one pixel, after an optional gap, and returns once it is taken
	task automatic send_pixel(input pix_item_t it);
		int gap;
		gap = 0;
		if (gap_weight > 0 && $urandom_range(0, 9) < gap_weight) begin
			gap = $urandom_range(1, 16);
		end
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		red <= it.red;
		green <= it.green;
		blue <= it.blue;
		frame_start <= it.frame_start;
		row_pinned <= it.pinned;
		row_first <= it.pin_first;
		row_second <= it.pin_second;
		@(posedge clk);
		while (!pix_ready) @(posedge clk);
	endtask

	always @(posedge clk) begin
		yuv_word_t want;
		yuv_word_t got;
		bit word_due;
		if (arst_n) begin
			if (word_valid && word_ready) begin
				if (pending_words.size() == 0) begin
					$error("word with no pair pending: first %h second %h",
						word_first, word_second);
					mismatches++;
				end else begin
					want = pending_words.pop_front();
					if (word_first !== want.first) begin
						$error("word_first: expected %h, got %h", want.first, word_first);
						mismatches++;
					end
					if (word_second !== want.second) begin
						$error("word_second: expected %h, got %h", want.second, word_second);
						mismatches++;
					end
				end
			end
			if (pix_valid && pix_ready) begin
				pack_pixel(red, green, blue, frame_start, word_due, got);
				if (word_due) begin
					if (row_pinned) begin
						got.first = row_first;
						got.second = row_second;
					end
					pending_words.push_back(got);
				end
				pix_taken <= pix_taken + 1;
			end
		end
	end

	// watchdog on cycles with no pixel or word moving on either side
	always @(posedge clk) begin
		if ((pix_valid && pix_ready) || (word_valid && word_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver: ready bursts, short stalls, and one long hold-off
	initial begin
		int span;
		while (!arst_n) @(posedge clk);
		forever begin
			if (!long_hold_done && pix_taken >= HOLD_AFTER) begin
				long_hold_done = 1'b1;
				word_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				word_ready <= 1'b0;
				span = $urandom_range(1, 16);
				repeat (span) @(posedge clk);
			end else begin
				word_ready <= 1'b1;
				span = calm ? 1 : $urandom_range(1, 24);
				repeat (span) @(posedge clk);
			end
		end
	end

	initial begin
		int i;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_weight = 2;
		for (i = 0; i < $size(directed_rows); i++) begin
			send_pixel(directed_rows[i]);
		end
		for (i = 0; i < RANDOM_PIX; i++) begin
			if (i >= RANDOM_PIX - CALM_PIX) begin
				calm <= 1'b1;
				gap_weight = 0;
			end else if (i % 50 == 0) begin
				gap_weight = $urandom_range(0, 4);
			end
			send_pixel(random_pixel());
		end
		pix_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
